@@ design/keypad_calculator_fsm_macros.svh @@
// Assertion macros for the keypad calculator.
// Used by keypad_calculator_fsm.sv; expects i_clk and i_rst_n in scope.
`ifndef KEYPAD_CALCULATOR_FSM_MACROS_SVH
`define KEYPAD_CALCULATOR_FSM_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is held.
`define KPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define KPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KPC_ASSERT_NOW(lbl, ante, cons, msg)
`define KPC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/kpc_pkg.sv @@
// Shared types, key codes and helpers for the keypad calculator.
// No dependencies; used by kpc_alu and keypad_calculator_fsm.
package kpc_pkg;

    localparam int MAX_DIGITS_DEF = 3;
    localparam int ANS_W          = 21;
    localparam int KEY_W          = 8;
    localparam int OUT_W          = 32;

    localparam logic [7:0] KEY_ZERO = 8'h30;
    localparam logic [7:0] KEY_NINE = 8'h39;
    localparam logic [7:0] KEY_A    = 8'h41;
    localparam logic [7:0] KEY_D    = 8'h44;
    localparam logic [7:0] KEY_HASH = 8'h23;
    localparam logic [7:0] KEY_STAR = 8'h2A;

    localparam logic [7:0] CH_NONE  = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h58;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef enum logic [2:0] {
        EV_IGNORED   = 3'd0,
        EV_DIGIT     = 3'd1,
        EV_OPERATOR  = 3'd2,
        EV_BACKSPACE = 3'd3,
        EV_RESULT    = 3'd4,
        EV_DIV_ZERO  = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ALU_MAC,
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV_STEP
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        logic    shift_in;
    } t_alu_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_CALC,
        S_DIV,
        S_OUT
    } t_state;

    function automatic logic [7:0] op_char(input t_op op);
        logic [7:0] ch;
        case (op)
            OP_ADD:  ch = CH_PLUS;
            OP_SUB:  ch = CH_MINUS;
            OP_MUL:  ch = CH_TIMES;
            default: ch = CH_SLASH;
        endcase
        return ch;
    endfunction

endpackage

@@ design/kpc_alu.sv @@
// Shared arithmetic unit of the keypad calculator: digit accumulate,
// add, subtract, multiply and one restoring divide step. Depends on kpc_pkg.
module kpc_alu #(
    parameter int  MAX_DIGITS = kpc_pkg::MAX_DIGITS_DEF,
    localparam int VAL_W      = $clog2(10 ** MAX_DIGITS)
) (
    input  kpc_pkg::t_alu_ctl         i_ctl,
    input  logic [VAL_W-1:0]          i_a,
    input  logic [VAL_W-1:0]          i_b,
    output logic [kpc_pkg::ANS_W-1:0] o_res,
    output logic [VAL_W-1:0]          o_rem,
    output logic                      o_qbit
);
    import kpc_pkg::*;

    localparam int PROD_W = (2 * VAL_W > ANS_W) ? 2 * VAL_W : ANS_W;

    logic [PROD_W-1:0] a_w;
    logic [PROD_W-1:0] b_w;
    logic [PROD_W-1:0] mul_w;
    logic [PROD_W-1:0] sum_w;
    logic [PROD_W-1:0] diff_w;
    logic [PROD_W-1:0] mac_w;
    logic [VAL_W:0]    rem_sh;
    logic [VAL_W:0]    rem_sub;

    assign a_w    = PROD_W'(i_a);
    assign b_w    = PROD_W'(i_b);
    assign mul_w  = a_w * b_w;
    assign sum_w  = a_w + b_w;
    // Low bits of the wrapped difference are the two's complement answer.
    assign diff_w = a_w - b_w;
    assign mac_w  = (a_w << 3) + (a_w << 1) + PROD_W'(i_b[3:0]);

    assign rem_sh  = {i_a, i_ctl.shift_in};
    assign rem_sub = rem_sh - (VAL_W + 1)'(i_b);

    always_comb begin
        o_qbit = (rem_sh >= {1'b0, i_b});
        o_rem  = o_qbit ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
    end

    always_comb begin
        case (i_ctl.op)
            ALU_MAC: o_res = mac_w[ANS_W-1:0];
            ALU_ADD: o_res = sum_w[ANS_W-1:0];
            ALU_SUB: o_res = diff_w[ANS_W-1:0];
            ALU_MUL: o_res = mul_w[ANS_W-1:0];
            default: o_res = '0;
        endcase
    end

endmodule

@@ design/keypad_calculator_fsm.sv @@
// Top level of the keypad four-function calculator.
// Depends on kpc_pkg, kpc_alu and keypad_calculator_fsm_macros.svh.
//
//  Channel  Direction  Payload (lowest bit first)
//  s        in         tdata[7:0] key_code
//  m        out        tdata event_kind[2:0], echo_char[10:3], answer[31:11]
//
// Digits and backspace go from S_IDLE through S_OUT to the output register.
// Operator and equals keys accumulate digits in S_ACC; equals then runs
// S_CALC, and a divide adds VAL_W restoring steps (10 for three digits) in
// S_DIV, all on the one shared arithmetic unit. The input is not ready until
// the result has moved into the output register; a stalled output holds the
// block there. Reset is synchronous and active low and clears all operands.
`include "keypad_calculator_fsm_macros.svh"

module keypad_calculator_fsm #(
    parameter int MAX_DIGITS = kpc_pkg::MAX_DIGITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [kpc_pkg::KEY_W-1:0] i_s_tdata,   // key_code[7:0]
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [kpc_pkg::OUT_W-1:0] o_m_tdata    // event_kind, echo_char, answer
);
    import kpc_pkg::*;

    localparam int VAL_W  = $clog2(10 ** MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int STEP_W = $clog2(VAL_W);

    t_state            r_state;
    t_state            n_state;
    logic              r_phase;
    logic [3:0]        r_first_digits [MAX_DIGITS];
    logic [3:0]        r_second_digits[MAX_DIGITS];
    logic [CNT_W-1:0]  r_first_count;
    logic [CNT_W-1:0]  r_second_count;
    t_op               r_op;
    logic [VAL_W-1:0]  r_first_value;
    logic [VAL_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_idx;
    logic              r_is_eq;
    logic [VAL_W-1:0]  r_rem;
    logic [VAL_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_step;
    t_event            r_kind;
    logic [7:0]        r_echo;
    logic [ANS_W-1:0]  r_ans;
    logic              r_m_valid;
    logic [OUT_W-1:0]  r_m_data;

    logic [7:0]        key;
    logic [7:0]        dig_raw;
    logic [7:0]        op_raw;
    logic              is_digit;
    logic              is_hash;
    logic              is_op;
    logic              is_eq_key;
    logic [CNT_W-1:0]  cur_count;
    logic              cnt_full;
    logic              accept;
    logic              acc_done;
    logic              div_last;
    logic              out_free;
    logic [3:0]        acc_digit;
    logic [VAL_W-1:0]  quo_next;

    t_alu_ctl          alu_ctl;
    logic [VAL_W-1:0]  alu_a;
    logic [VAL_W-1:0]  alu_b;
    logic [ANS_W-1:0]  alu_res;
    logic [VAL_W-1:0]  alu_rem;
    logic              alu_qbit;

    kpc_alu #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_alu (
        .i_ctl (alu_ctl),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res),
        .o_rem (alu_rem),
        .o_qbit(alu_qbit)
    );

    // Key decode and shared status.
    always_comb begin
        key       = i_s_tdata;
        dig_raw   = key - KEY_ZERO;
        op_raw    = key - KEY_A;
        is_digit  = key inside {[KEY_ZERO:KEY_NINE]};
        is_hash   = (key == KEY_HASH);
        is_op     = !r_phase && (key inside {[KEY_A:KEY_D]});
        is_eq_key = r_phase && (key == KEY_STAR);
        cur_count = r_phase ? r_second_count : r_first_count;
        cnt_full  = (cur_count == CNT_W'(MAX_DIGITS));
        accept    = i_s_tvalid && o_s_tready;
        acc_done  = (r_idx == cur_count);
        div_last  = (r_step == STEP_W'(VAL_W - 1));
        out_free  = !r_m_valid || i_m_tready;
        acc_digit = r_phase ? r_second_digits[r_idx[IDX_W-1:0]]
                            : r_first_digits[r_idx[IDX_W-1:0]];
        quo_next  = {r_quo[VAL_W-2:0], alu_qbit};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (is_op || is_eq_key) ? S_ACC : S_OUT;
                end
            end
            S_ACC: begin
                if (acc_done) begin
                    n_state = r_is_eq ? S_CALC : S_OUT;
                end
            end
            S_CALC: begin
                n_state = (r_op == OP_DIV && r_acc != '0) ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and the shared unit's operands.
    always_comb begin
        o_s_tready       = 1'b0;
        alu_ctl.op       = ALU_MAC;
        alu_ctl.shift_in = 1'b0;
        alu_a            = '0;
        alu_b            = '0;
        case (r_state)
            S_IDLE: o_s_tready = 1'b1;
            S_ACC: begin
                alu_ctl.op = ALU_MAC;
                alu_a      = r_acc;
                alu_b      = VAL_W'(acc_digit);
            end
            S_CALC: begin
                case (r_op)
                    OP_ADD:  alu_ctl.op = ALU_ADD;
                    OP_SUB:  alu_ctl.op = ALU_SUB;
                    OP_MUL:  alu_ctl.op = ALU_MUL;
                    default: alu_ctl.op = ALU_DIV_STEP;
                endcase
                alu_a = r_first_value;
                alu_b = r_acc;
            end
            S_DIV: begin
                alu_ctl.op       = ALU_DIV_STEP;
                alu_ctl.shift_in = r_quo[VAL_W-1];
                alu_a            = r_rem;
                alu_b            = r_acc;
            end
            default: o_s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_phase        <= 1'b0;
            r_first_count  <= '0;
            r_second_count <= '0;
            r_op           <= OP_ADD;
            r_first_value  <= '0;
            r_is_eq        <= 1'b0;
            r_m_valid      <= 1'b0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_first_digits[i]  <= '0;
                r_second_digits[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (r_state == S_OUT && out_free) begin
                r_m_valid <= 1'b1;
                r_m_data  <= {r_ans, r_echo, r_kind};
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_acc   <= '0;
                        r_idx   <= '0;
                        r_is_eq <= is_eq_key;
                        r_kind  <= EV_IGNORED;
                        r_echo  <= CH_NONE;
                        r_ans   <= '0;
                        if (is_digit) begin
                            if (!cnt_full) begin
                                if (r_phase) begin
                                    r_second_digits[cur_count[IDX_W-1:0]] <= dig_raw[3:0];
                                    r_second_count <= cur_count + CNT_W'(1);
                                end else begin
                                    r_first_digits[cur_count[IDX_W-1:0]] <= dig_raw[3:0];
                                    r_first_count <= cur_count + CNT_W'(1);
                                end
                                r_kind <= EV_DIGIT;
                                r_echo <= key;
                            end
                        end else if (is_hash) begin
                            // Digits above the count are never read, so no clear.
                            if (cur_count != '0) begin
                                if (r_phase) begin
                                    r_second_count <= cur_count - CNT_W'(1);
                                end else begin
                                    r_first_count <= cur_count - CNT_W'(1);
                                end
                            end
                            r_kind <= EV_BACKSPACE;
                        end else if (is_op) begin
                            r_op   <= t_op'(op_raw[1:0]);
                            r_kind <= EV_OPERATOR;
                            r_echo <= op_char(t_op'(op_raw[1:0]));
                        end else if (is_eq_key) begin
                            r_echo <= CH_EQ;
                        end
                    end
                end
                S_ACC: begin
                    if (!acc_done) begin
                        r_acc <= alu_res[VAL_W-1:0];
                        r_idx <= r_idx + CNT_W'(1);
                    end else if (!r_is_eq) begin
                        r_first_value <= r_acc;
                        r_phase       <= 1'b1;
                    end
                end
                S_CALC: begin
                    if (r_op == OP_DIV && r_acc != '0) begin
                        r_rem  <= '0;
                        r_quo  <= r_first_value;
                        r_step <= '0;
                    end else begin
                        if (r_op == OP_DIV) begin
                            r_kind <= EV_DIV_ZERO;
                        end else begin
                            r_kind <= EV_RESULT;
                            r_ans  <= alu_res;
                        end
                        r_phase        <= 1'b0;
                        r_first_count  <= '0;
                        r_second_count <= '0;
                    end
                end
                S_DIV: begin
                    r_rem  <= alu_rem;
                    r_quo  <= quo_next;
                    r_step <= r_step + STEP_W'(1);
                    if (div_last) begin
                        r_kind         <= EV_RESULT;
                        r_ans          <= ANS_W'(quo_next);
                        r_phase        <= 1'b0;
                        r_first_count  <= '0;
                        r_second_count <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    `KPC_ASSERT_NXT(a_busy_after_req, accept, !o_s_tready, "block still ready after a request")
    `KPC_ASSERT_NOW(a_count_bound, 1'b1, (r_first_count <= CNT_W'(MAX_DIGITS)) && (r_second_count <= CNT_W'(MAX_DIGITS)), "digit count beyond limit")
    `KPC_ASSERT_NOW(a_div_nonzero, r_state == S_DIV, r_acc != '0, "divide started with zero divisor")
    `KPC_ASSERT_NXT(a_calc_clears, (r_state == S_CALC) && (r_op != OP_DIV), !r_phase && (r_first_count == '0) && (r_second_count == '0), "operands not cleared after result")

endmodule
